/* design/tcw_pkg.sv */
`default_nettype none

package tcw_pkg;

    // screen geometry defaults
    localparam int ROWS_DEFAULT = 22;
    localparam int COLS_DEFAULT = 32;

    // fixed field widths of the channels
    localparam int CMD_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int COORD_W = 5;

    localparam logic [CHAR_W-1:0] SPACE_CODE = 8'd32;
    localparam logic [CHAR_W-1:0] LF_CODE    = 8'd10;
    localparam logic [CHAR_W-1:0] CR_CODE    = 8'd13;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_SETXY = 2'd3
    } t_cmd;

endpackage

`default_nettype wire

/* design/text_console_writer.sv */
// text console writer: a character screen with a cursor, held in one
// single-port-write, single-port-read RAM of ROWS*COLS bytes.
// input channel: i_in_valid / o_in_stall with i_cmd, i_char_code, i_row_sel,
// i_col_sel. a transfer happens when valid is high and stall is low.
// output channel: o_out_valid / i_out_stall with o_cell_data, o_cursor_col,
// o_cursor_row, o_scrolled; exactly one result per accepted command.
// the block takes one command at a time; stall stays high until the
// sequencer is back in idle.
// a put, a set cursor and an out-of-range read go from execute straight to
// done; an in-range read passes through a RAM read state; a put that
// scrolls and a clear screen pass through the address counter that walks
// the RAM one cell per cycle (scroll copies a cell from the row below each
// cycle, then fills the bottom row with spaces).
// the result sits in an output register, so the next command is taken
// while it waits; a stalled receiver only holds the block once a second
// result is ready.
// after reset the RAM is swept to spaces with stall high and no result;
// the cursor starts at row 0, column 0.
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int ROWS = ROWS_DEFAULT,
    parameter int COLS = COLS_DEFAULT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [CMD_W-1:0]   i_cmd,
    input  wire logic [CHAR_W-1:0]  i_char_code,
    input  wire logic [COORD_W-1:0] i_row_sel,
    input  wire logic [COORD_W-1:0] i_col_sel,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic      [CHAR_W-1:0]  o_cell_data,
    output logic      [COORD_W-1:0] o_cursor_col,
    output logic      [COORD_W-1:0] o_cursor_row,
    output logic                    o_scrolled
);

    localparam int CELLS  = ROWS * COLS;
    localparam int MOVES  = (ROWS - 1) * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int IDX_W  = $clog2(CELLS + 1);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SCROLL,
        S_CLEAR,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_report, n_report;
    logic               r_scrolled, n_scrolled;
    logic [CHAR_W-1:0]  r_data, n_data;

    t_cmd               r_cmd;
    logic [CHAR_W-1:0]  r_char;
    logic [COORD_W-1:0] r_rsel;
    logic [COORD_W-1:0] r_csel;

    // write-back stage in front of the RAM write port
    logic               r_wb_valid, n_wb_valid;
    logic               r_wb_from_mem, n_wb_from_mem;
    logic [ADDR_W-1:0]  r_wb_addr, n_wb_addr;
    logic [CHAR_W-1:0]  r_wb_data, n_wb_data;

    logic               r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]  r_out_data, n_out_data;
    logic [COORD_W-1:0] r_out_col, n_out_col;
    logic [COORD_W-1:0] r_out_row, n_out_row;
    logic               r_out_scrolled, n_out_scrolled;

    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [CHAR_W-1:0]  rd_data;
    logic [CHAR_W-1:0]  wr_data;
    logic [ADDR_W-1:0]  cur_addr;
    logic [ADDR_W-1:0]  sel_addr;
    logic               sel_in_range;
    logic               in_xfer;
    logic               out_free;

    assign in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    assign cur_addr = ADDR_W'(r_row) * ADDR_W'(COLS) + ADDR_W'(r_col);
    assign sel_addr = ADDR_W'(r_rsel) * ADDR_W'(COLS) + ADDR_W'(r_csel);
    assign sel_in_range = (32'(r_rsel) < ROWS) && (32'(r_csel) < COLS);

    assign wr_data = r_wb_from_mem ? rd_data : r_wb_data;

    tcw_screen_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_wb_valid),
        .i_waddr (r_wb_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state        = r_state;
        n_row          = r_row;
        n_col          = r_col;
        n_idx          = r_idx;
        n_report       = r_report;
        n_scrolled     = r_scrolled;
        n_data         = r_data;
        n_wb_valid     = 1'b0;
        n_wb_from_mem  = 1'b0;
        n_wb_addr      = r_wb_addr;
        n_wb_data      = r_wb_data;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out_data     = r_out_data;
        n_out_col      = r_out_col;
        n_out_row      = r_out_row;
        n_out_scrolled = r_out_scrolled;
        rd_en          = 1'b0;
        rd_addr        = sel_addr;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state    = S_EXEC;
                    n_scrolled = 1'b0;
                    n_data     = '0;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_cmd)
                    CMD_PUT: begin
                        if (r_char != LF_CODE && r_char != CR_CODE) begin
                            n_wb_valid = 1'b1;
                            n_wb_addr  = cur_addr;
                            n_wb_data  = r_char;
                        end
                        if (r_char == LF_CODE || r_char == CR_CODE ||
                            32'(r_col) == COLS - 1) begin
                            n_col = '0;
                            if (32'(r_row) == ROWS - 1) begin
                                n_scrolled = 1'b1;
                                n_idx      = '0;
                                n_state    = S_SCROLL;
                            end else begin
                                n_row = r_row + 1'b1;
                            end
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                    end
                    CMD_CLEAR: begin
                        n_row    = '0;
                        n_col    = '0;
                        n_idx    = '0;
                        n_report = 1'b1;
                        n_state  = S_CLEAR;
                    end
                    CMD_READ: begin
                        if (sel_in_range) begin
                            rd_en   = 1'b1;
                            n_state = S_READ;
                        end
                    end
                    CMD_SETXY: begin
                        n_row = (32'(r_rsel) < ROWS) ? ROW_W'(r_rsel) : ROW_W'(ROWS - 1);
                        n_col = (32'(r_csel) < COLS) ? COL_W'(r_csel) : COL_W'(COLS - 1);
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_READ: begin
                n_data  = rd_data;
                n_state = S_DONE;
            end
            S_SCROLL: begin
                // read one row ahead, write the cell back in the next cycle
                if (32'(r_idx) < MOVES) begin
                    rd_en         = 1'b1;
                    rd_addr       = r_idx[ADDR_W-1:0] + ADDR_W'(COLS);
                    n_wb_valid    = 1'b1;
                    n_wb_from_mem = 1'b1;
                    n_wb_addr     = r_idx[ADDR_W-1:0];
                    n_idx         = r_idx + 1'b1;
                end else if (32'(r_idx) < CELLS) begin
                    n_wb_valid = 1'b1;
                    n_wb_addr  = r_idx[ADDR_W-1:0];
                    n_wb_data  = SPACE_CODE;
                    n_idx      = r_idx + 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CLEAR: begin
                if (32'(r_idx) < CELLS) begin
                    n_wb_valid = 1'b1;
                    n_wb_addr  = r_idx[ADDR_W-1:0];
                    n_wb_data  = SPACE_CODE;
                    n_idx      = r_idx + 1'b1;
                end else begin
                    // the sweep after reset gives no result
                    n_state = r_report ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_out_data     = r_data;
                    n_out_col      = COORD_W'(r_col);
                    n_out_row      = COORD_W'(r_row);
                    n_out_scrolled = r_scrolled;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_row       <= '0;
            r_col       <= '0;
            r_idx       <= '0;
            r_report    <= 1'b0;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_idx       <= n_idx;
            r_report    <= n_report;
            r_wb_valid  <= n_wb_valid;
            r_out_valid <= n_out_valid;
        end
        r_scrolled     <= n_scrolled;
        r_data         <= n_data;
        r_wb_from_mem  <= n_wb_from_mem;
        r_wb_addr      <= n_wb_addr;
        r_wb_data      <= n_wb_data;
        r_out_data     <= n_out_data;
        r_out_col      <= n_out_col;
        r_out_row      <= n_out_row;
        r_out_scrolled <= n_out_scrolled;
        if (in_xfer) begin
            r_cmd  <= t_cmd'(i_cmd);
            r_char <= i_char_code;
            r_rsel <= i_row_sel;
            r_csel <= i_col_sel;
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cell_data  = r_out_data;
    assign o_cursor_col = r_out_col;
    assign o_cursor_row = r_out_row;
    assign o_scrolled   = r_out_scrolled;

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_row) < ROWS) && (32'(r_col) < COLS))
        else $error("cursor outside the screen");

    a_wb_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_valid |-> (32'(r_wb_addr) < CELLS))
        else $error("write-back address outside the screen");

    a_scroll_home_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_scrolled) |-> (r_out_col == '0))
        else $error("scrolled result with cursor not in column 0");

    a_read_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL && rd_en) |=> r_wb_valid && r_wb_from_mem)
        else $error("scroll read without matching write-back");

endmodule

`default_nettype wire

/* design/tcw_screen_ram.sv */
`default_nettype none

module tcw_screen_ram
    import tcw_pkg::*;
#(
    parameter int DEPTH  = ROWS_DEFAULT * COLS_DEFAULT,
    parameter int ADDR_W = $clog2(ROWS_DEFAULT * COLS_DEFAULT)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [CHAR_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [CHAR_W-1:0] o_rdata
);

    logic [CHAR_W-1:0] r_mem [DEPTH];
    logic [CHAR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import tcw_pkg::*;

    localparam int NROWS = ROWS_DEFAULT;
    localparam int NCOLS = COLS_DEFAULT;
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int RANDOM_ITEMS = 1950;
    // a scroll or a clear walks the whole store
    localparam int SETTLE_CYCLES = NROWS * NCOLS + 20;

    typedef struct packed {
        logic [CHAR_W-1:0]  cell_data;
        logic [COORD_W-1:0] cursor_col;
        logic [COORD_W-1:0] cursor_row;
        logic               scrolled;
    } t_cursor_report;

    class screen_tracker;
        logic [CHAR_W-1:0]  cells [NROWS*NCOLS];
        logic [COORD_W-1:0] cur_col;
        logic [COORD_W-1:0] cur_row;
        t_cursor_report     pending_reports [$];
        int errors;
        int commands;
        int reads;
        int scrolls;
        int clears;

        function new();
            errors = 0;
            commands = 0;
            reads = 0;
            scrolls = 0;
            clears = 0;
            blank_screen();
        endfunction

        function void blank_screen();
            foreach (cells[i]) cells[i] = SPACE_CODE;
            cur_col = '0;
            cur_row = '0;
        endfunction

        // returns 1 when the screen moved up one row
        function bit advance_line();
            cur_col = '0;
            if (cur_row == NROWS - 1) begin
                for (int i = 0; i < (NROWS - 1) * NCOLS; i++) cells[i] = cells[i + NCOLS];
                for (int i = (NROWS - 1) * NCOLS; i < NROWS * NCOLS; i++)
                    cells[i] = SPACE_CODE;
                return 1'b1;
            end
            cur_row = cur_row + 1'b1;
            return 1'b0;
        endfunction

        function void apply_command(t_cmd cmd, logic [CHAR_W-1:0] code,
                                    logic [COORD_W-1:0] rsel, logic [COORD_W-1:0] csel);
            t_cursor_report rep;
            rep.cell_data = '0;
            rep.scrolled = 1'b0;
            commands++;
            case (cmd)
                CMD_PUT: begin
                    if (code == LF_CODE || code == CR_CODE) begin
                        rep.scrolled = advance_line();
                    end else begin
                        cells[int'(cur_row) * NCOLS + int'(cur_col)] = code;
                        if (cur_col == NCOLS - 1) rep.scrolled = advance_line();
                        else cur_col = cur_col + 1'b1;
                    end
                end
                CMD_CLEAR: begin
                    blank_screen();
                    clears++;
                end
                CMD_READ: begin
                    reads++;
                    if (rsel < NROWS && csel < NCOLS)
                        rep.cell_data = cells[int'(rsel) * NCOLS + int'(csel)];
                end
                CMD_SETXY: begin
                    cur_row = (rsel < NROWS) ? rsel : COORD_W'(NROWS - 1);
                    cur_col = (csel < NCOLS) ? csel : COORD_W'(NCOLS - 1);
                end
                default: ;
            endcase
            if (rep.scrolled) scrolls++;
            rep.cursor_col = cur_col;
            rep.cursor_row = cur_row;
            pending_reports.push_back(rep);
        endfunction

        function void compare_report(t_cursor_report got);
            t_cursor_report exp;
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result, cell_data %0d col %0d row %0d scrolled %0d",
                         $time, got.cell_data, got.cursor_col, got.cursor_row, got.scrolled);
                errors++;
                return;
            end
            exp = pending_reports.pop_front();
            if (got.cell_data !== exp.cell_data) begin
                $display("%0t: cell_data expected %0d, got %0d",
                         $time, exp.cell_data, got.cell_data);
                errors++;
            end
            if (got.cursor_col !== exp.cursor_col) begin
                $display("%0t: cursor_col expected %0d, got %0d",
                         $time, exp.cursor_col, got.cursor_col);
                errors++;
            end
            if (got.cursor_row !== exp.cursor_row) begin
                $display("%0t: cursor_row expected %0d, got %0d",
                         $time, exp.cursor_row, got.cursor_row);
                errors++;
            end
            if (got.scrolled !== exp.scrolled) begin
                $display("%0t: scrolled expected %0d, got %0d",
                         $time, exp.scrolled, got.scrolled);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic [CMD_W-1:0]   in_cmd = '0;
    logic [CHAR_W-1:0]  in_char = '0;
    logic [COORD_W-1:0] in_row = '0;
    logic [COORD_W-1:0] in_col = '0;
    logic               out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [CHAR_W-1:0]  o_cell_data;
    logic [COORD_W-1:0] o_cursor_col;
    logic [COORD_W-1:0] o_cursor_row;
    logic               o_scrolled;

    screen_tracker screen;
    bit calm = 1'b0;
    int items_sent = 0;
    int cycles = 0;
    int stall_left = 0;

    text_console_writer i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (in_cmd),
        .i_char_code  (in_char),
        .i_row_sel    (in_row),
        .i_col_sel    (in_col),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .o_cell_data  (o_cell_data),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_scrolled   (o_scrolled)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // mostly short idle stretches, now and then a long one
    function automatic int idle_length();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side: sample at the edge, then pick the stall for the next cycle
    initial begin
        t_cursor_report got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && out_stall == 1'b0) begin
                got.cell_data = o_cell_data;
                got.cursor_col = o_cursor_col;
                got.cursor_row = o_cursor_row;
                got.scrolled = o_scrolled;
                screen.compare_report(got);
            end
            if (stall_left > 0) stall_left--;
            else if ($urandom_range(0, 99) < 25) stall_left = idle_length();
            out_stall <= (stall_left > 0);
        end
    end

    task automatic send_command(t_cmd cmd, logic [CHAR_W-1:0] code,
                                logic [COORD_W-1:0] rsel, logic [COORD_W-1:0] csel);
        int gap;
        gap = idle_length();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_cmd <= cmd;
        in_char <= code;
        in_row <= rsel;
        in_col <= csel;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        screen.apply_command(cmd, code, rsel, csel);
        items_sent++;
    endtask

    task automatic put_char(logic [CHAR_W-1:0] code);
        send_command(CMD_PUT, code, COORD_W'($urandom), COORD_W'($urandom));
    endtask

    task automatic read_cell(logic [COORD_W-1:0] rsel, logic [COORD_W-1:0] csel);
        send_command(CMD_READ, CHAR_W'($urandom), rsel, csel);
    endtask

    task automatic place_cursor(logic [COORD_W-1:0] rsel, logic [COORD_W-1:0] csel);
        send_command(CMD_SETXY, CHAR_W'($urandom), rsel, csel);
    endtask

    task automatic type_text(int n);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0) put_char(CHAR_W'($urandom));
            else put_char(CHAR_W'($urandom_range(33, 126)));
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (screen.pending_reports.size() > 0);
    endtask

    initial begin
        int kind;
        screen = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: corners of the fields and each special case
        read_cell(5'd0, 5'd0);
        put_char(8'd65);
        put_char(8'h00);
        put_char(8'hFF);
        read_cell(5'd0, 5'd1);
        read_cell(5'd0, 5'd2);
        put_char(LF_CODE);
        put_char(CR_CODE);
        place_cursor(5'd21, 5'd31);
        put_char(8'd90);            // last cell: wraps and scrolls
        read_cell(5'd20, 5'd31);
        place_cursor(5'd31, 5'd31); // saturates the row coordinate
        place_cursor(5'd22, 5'd0);
        place_cursor(5'd21, 5'd5);
        put_char(LF_CODE);          // newline on the bottom row scrolls
        read_cell(5'd22, 5'd0);
        read_cell(5'd31, 5'd31);
        read_cell(5'd21, 5'd31);
        place_cursor(5'd16, 5'd16);
        put_char(8'd126);
        read_cell(5'd16, 5'd16);
        send_command(CMD_CLEAR, 8'hFF, 5'd31, 5'd31);
        read_cell(5'd16, 5'd16);
        put_char(8'd120);
        wait_drained();

        while (items_sent < RANDOM_ITEMS + 25) begin
            calm = ($urandom_range(0, 9) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                type_text($urandom_range(1, 40));
                if ($urandom_range(0, 2) != 0) put_char($urandom_range(0, 1) ? LF_CODE : CR_CODE);
            end else if (kind < 60) begin
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 4) == 0)
                        read_cell(COORD_W'($urandom), COORD_W'($urandom));
                    else
                        read_cell(COORD_W'($urandom_range(0, NROWS - 1)),
                                  COORD_W'($urandom_range(0, NCOLS - 1)));
                end
            end else if (kind < 72) begin
                place_cursor(COORD_W'($urandom), COORD_W'($urandom));
                type_text($urandom_range(0, 10));
            end else if (kind < 80) begin
                // land near the end of a line to exercise the wrap
                place_cursor(COORD_W'($urandom_range(0, NROWS - 1)),
                             COORD_W'($urandom_range(NCOLS - 6, NCOLS - 1)));
                type_text($urandom_range(1, 8));
            end else if (kind < 83) begin
                place_cursor(COORD_W'(NROWS - 1), COORD_W'($urandom));
                repeat ($urandom_range(1, 3)) put_char($urandom_range(0, 1) ? LF_CODE : CR_CODE);
            end else if (kind < 93) begin
                repeat ($urandom_range(1, 4)) begin
                    t_cmd c;
                    c = t_cmd'($urandom_range(0, 3));
                    if (c == CMD_CLEAR && $urandom_range(0, 3) != 0) c = CMD_READ;
                    send_command(c, CHAR_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
                end
            end else if (kind < 95) begin
                send_command(CMD_CLEAR, CHAR_W'($urandom), COORD_W'($urandom),
                             COORD_W'($urandom));
            end else if (kind < 97) begin
                wait_drained();
            end else begin
                place_cursor(COORD_W'(NROWS - 1), 5'd0);
                type_text($urandom_range(30, 40));
            end
        end

        calm = 1'b0;
        in_valid <= 1'b0;
        while (screen.pending_reports.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run covered %0d commands: %0d reads, %0d scrolls, %0d screen clears",
                 screen.commands, screen.reads, screen.scrolls, screen.clears);
        $display("field mismatches or stray transfers: %0d", screen.errors);
        if (screen.errors == 0 && screen.pending_reports.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
